// ===== hdl/fbs_pkg.sv =====
package fbs_pkg;

	localparam int MAX_TAPS = 7;
	localparam int PIX_W    = 8;
	localparam int WGT_W    = 17;
	localparam int TAP_W    = 3;
	localparam int IDX_W    = 3;
	localparam int PROD_W   = PIX_W + WGT_W;
	localparam int FRAC_W   = 16;

	localparam logic [WGT_W-1:0] WEIGHT_ONE_Q16 = 17'h10000;

	typedef logic [PIX_W-1:0] byte_t;
	typedef logic [WGT_W-1:0] weight_t;
	typedef logic [TAP_W-1:0] taps_t;

	typedef enum logic [IDX_W-1:0] {
		REG_TAP_COUNT    = 3'd0,
		REG_WEIGHT_ZERO  = 3'd1,
		REG_WEIGHT_ONE   = 3'd2,
		REG_WEIGHT_TWO   = 3'd3,
		REG_WEIGHT_THREE = 3'd4,
		REG_WEIGHT_FOUR  = 3'd5,
		REG_WEIGHT_FIVE  = 3'd6,
		REG_WEIGHT_SIX   = 3'd7
	} reg_idx_t;

	// token travelling beside the data of one pipeline stage
	typedef struct packed {
		logic valid;
		logic last;
	} tok_t;

endpackage

// ===== hdl/fir_byte_stream_filter.sv =====
// Byte-stream FIR filter with up to seven forward-looking taps.
// Input words arrive on s_axis: tdata carries the pixel, tlast marks the
// final byte of an image. Filtered words leave on m_axis with tlast on the
// final filtered byte of the image. Output y is the sum of the truncated
// terms pixel[y+i]*weight_i over the taps in use, wrapping modulo 256.
// The cfg port (cfg_we, cfg_index, cfg_data) sets tap_count (index 0) and
// the seven Q1.16 weights (indices 1 to 7); write it only while idle.
// Throughput is one word per cycle unless a flush or an m_axis stall holds it.
// Output y leaves after the word carrying pixel y+taps-1 is accepted, passing
// the cell row, the registered products, then the adder and output register.
// After a word with tlast the block pushes taps-1 zero bytes through the
// cell row, one per cycle unless stalled, holding s_axis_tready low meanwhile.
// When m_axis stalls, words keep being accepted until the three stages are
// full; then s_axis_tready drops. Reset gives one tap of weight 1.0, clears
// the cell row and empties the pipeline.
module fir_byte_stream_filter (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [fbs_pkg::IDX_W-1:0] cfg_index,
	input  logic [fbs_pkg::WGT_W-1:0] cfg_data,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [7:0]              s_axis_tdata,   // pixel_in
	input  logic                    s_axis_tlast,   // end_of_image
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [7:0]              m_axis_tdata,   // pixel_out
	output logic                    m_axis_tlast    // last_out
);
	import fbs_pkg::*;

	localparam taps_t CNT_MAX = taps_t'(MAX_TAPS);

	taps_t   tap_count_q;
	weight_t weight_q [MAX_TAPS];
	weight_t weight_sel [MAX_TAPS];
	taps_t   taps;
	taps_t   taps_m1;

	taps_t   cnt_q;
	taps_t   cnt_nxt;
	taps_t   flush_q;
	logic    flushing;
	logic    push;
	logic    real_push;
	logic    emit;
	logic    last_push;
	byte_t   push_byte;

	tok_t    tok_s0;
	tok_t    tok_s1;
	logic    rdy_out;
	logic    rdy1;
	logic    rdy0;

	byte_t   cell_byte [MAX_TAPS];
	byte_t   term_s1 [MAX_TAPS];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= taps_t'(1);
			weight_q[0] <= WEIGHT_ONE_Q16;
			for (int i = 1; i < MAX_TAPS; i++) begin
				weight_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_TAP_COUNT: begin
					tap_count_q <= cfg_data[TAP_W-1:0];
				end
				REG_WEIGHT_ZERO, REG_WEIGHT_ONE, REG_WEIGHT_TWO, REG_WEIGHT_THREE,
				REG_WEIGHT_FOUR, REG_WEIGHT_FIVE, REG_WEIGHT_SIX: begin
					weight_q[cfg_index - IDX_W'(1)] <= cfg_data;
				end
				default: begin
					tap_count_q <= tap_count_q;
				end
			endcase
		end
	end

	// a tap count of zero acts as one tap
	assign taps    = (tap_count_q == '0) ? taps_t'(1) : tap_count_q;
	assign taps_m1 = taps - taps_t'(1);

	// cell j holds the byte pushed j steps ago; it pairs with weight taps-1-j
	always_comb begin
		for (int j = 0; j < MAX_TAPS; j++) begin
			if (taps_t'(j) <= taps_m1) begin
				weight_sel[j] = weight_q[taps_m1 - taps_t'(j)];
			end else begin
				weight_sel[j] = '0;
			end
		end
	end

	// stage handshake, collapsing bubbles back from the output register
	assign rdy1 = !tok_s1.valid || rdy_out;
	assign rdy0 = !tok_s0.valid || rdy1;

	assign flushing      = (flush_q != '0);
	assign s_axis_tready = rdy0 && !flushing;
	assign real_push     = s_axis_tvalid && s_axis_tready;
	assign push          = real_push || (rdy0 && flushing);
	assign push_byte     = flushing ? '0 : s_axis_tdata;

	assign cnt_nxt   = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + taps_t'(1);
	assign emit      = (cnt_nxt >= taps);
	assign last_push = flushing ? (flush_q == taps_t'(1))
	                            : (s_axis_tlast && (taps == taps_t'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			flush_q <= '0;
		end else if (push) begin
			if (last_push) begin
				cnt_q   <= '0;
				flush_q <= '0;
			end else begin
				cnt_q <= cnt_nxt;
				if (flushing) begin
					flush_q <= flush_q - taps_t'(1);
				end else if (s_axis_tlast) begin
					flush_q <= taps_m1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s0 <= '0;
			tok_s1 <= '0;
		end else begin
			if (rdy0) begin
				tok_s0.valid <= push && emit;
				tok_s0.last  <= last_push;
			end
			if (rdy1) begin
				tok_s1 <= tok_s0;
			end
		end
	end

	for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
		fbs_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (push),
			.din     ((j == 0) ? push_byte : cell_byte[(j == 0) ? 0 : j - 1]),
			.weight  (weight_sel[j]),
			.load    (rdy1 && tok_s0.valid),
			.dout    (cell_byte[j]),
			.term_s1 (term_s1[j])
		);
	end

	fbs_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.tok_s1        (tok_s1),
		.term_s1       (term_s1),
		.ready         (rdy_out),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ===== hdl/fbs_cell.sv =====
module fbs_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift,
	input  fbs_pkg::byte_t din,
	input  fbs_pkg::weight_t weight,
	input  logic           load,
	output fbs_pkg::byte_t dout,
	output fbs_pkg::byte_t term_s1
);
	import fbs_pkg::*;

	byte_t                byte_q;
	logic [PROD_W-1:0]    prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift) begin
			byte_q <= din;
		end
	end

	// only the low byte of the truncated term survives the modulo-256 sum
	assign prod = PROD_W'(byte_q) * PROD_W'(weight);

	always_ff @(posedge clk) begin
		if (load) begin
			term_s1 <= prod[FRAC_W +: PIX_W];
		end
	end

	assign dout = byte_q;

endmodule

// ===== hdl/fbs_out.sv =====
module fbs_out (
	input  logic           clk,
	input  logic           arst_n,
	input  fbs_pkg::tok_t  tok_s1,
	input  fbs_pkg::byte_t term_s1 [fbs_pkg::MAX_TAPS],
	output logic           ready,
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	output logic [7:0]     m_axis_tdata,   // pixel_out
	output logic           m_axis_tlast
);
	import fbs_pkg::*;

	logic  valid_q;
	logic  last_q;
	byte_t data_q;
	byte_t sum;

	always_comb begin
		sum = '0;
		for (int i = 0; i < MAX_TAPS; i++) begin
			sum = sum + term_s1[i];
		end
	end

	assign ready = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= tok_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && tok_s1.valid) begin
			data_q <= sum;
			last_q <= tok_s1.last;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = data_q;
	assign m_axis_tlast  = last_q;

endmodule

// ===== tb/tb.sv =====
module tb;
	import fbs_pkg::*;

	localparam int SETTLE_CYCLES = 16;
	localparam int STALL_LIMIT   = 2000;
	localparam int RANDOM_PIXELS = 440;
	localparam int BURST_PIXELS  = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int WIN_DEPTH     = MAX_TAPS - 1;

	typedef struct packed {
		byte_t pix;
		logic  last;
	} filt_word_t;

	typedef struct {
		bit       is_cfg;
		reg_idx_t idx;
		weight_t  val;
		byte_t    pix;
		bit       eoi;
		bit       typed;
		byte_t    want_pix;
	} plan_row_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [IDX_W-1:0] cfg_index;
	weight_t    cfg_data;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic       s_axis_tlast;
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;

	fir_byte_stream_filter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// shadow of the filter state and registers
	byte_t       win_bytes[WIN_DEPTH];
	int unsigned win_fill;
	taps_t       taps_reg;
	weight_t     tap_wgt[MAX_TAPS];

	filt_word_t  filtered_q[$];
	int          mismatches = 0;
	int          tx_mode = 0;
	bit          busy = 1'b0;
	bit          hold_req = 1'b0;
	bit          hold_done = 1'b0;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic byte_t tap_sum(byte_t seq[MAX_TAPS], int unsigned len,
			int unsigned start, int unsigned taps);
		byte_t acc;
		logic [PROD_W-1:0] prod;
		acc = '0;
		for (int unsigned i = 0; i < taps; i++) begin
			// bytes past the end of the image count as zero
			prod = (start + i < len) ?
				PROD_W'(seq[start + i]) * PROD_W'(tap_wgt[i]) : '0;
			acc = acc + byte_t'(prod[PROD_W-1:FRAC_W]);
		end
		return acc;
	endfunction

	function automatic void predict_filter(byte_t pix, bit eoi);
		byte_t       seq[MAX_TAPS];
		filt_word_t  res[MAX_TAPS];
		int unsigned taps;
		int unsigned len;
		int unsigned flush;
		int unsigned keep;
		int          n;
		taps = (taps_reg == '0) ? 1 : 32'(taps_reg);
		n = 0;
		for (int i = 0; i < MAX_TAPS; i++) seq[i] = '0;
		for (int unsigned i = 0; i < win_fill; i++) seq[i] = win_bytes[i];
		seq[win_fill] = pix;
		len = win_fill + 1;
		if (len >= taps) begin
			res[n] = '{pix: tap_sum(seq, len, len - taps, taps), last: 1'b0};
			n++;
		end
		if (eoi) begin
			flush = (len < taps - 1) ? len : taps - 1;
			for (int unsigned s = len - flush; s < len; s++) begin
				res[n] = '{pix: tap_sum(seq, len, s, taps), last: 1'b0};
				n++;
			end
			res[n-1].last = 1'b1;
		end
		for (int i = 0; i < n; i++) filtered_q = {filtered_q, res[i]};
		if (eoi) begin
			win_fill = 0;
		end else begin
			keep = (len < WIN_DEPTH) ? len : WIN_DEPTH;
			for (int unsigned i = 0; i < keep; i++) win_bytes[i] = seq[len - keep + i];
			win_fill = keep;
		end
	endfunction

	function automatic int draw_gap(int mode);
		case (mode)
			0: return 0;
			1: return int'($urandom_range(0, 19));
			default: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 19)) : 0;
		endcase
	endfunction

	function automatic byte_t pick_pixel();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return byte_t'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic weight_t pick_weight();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return WEIGHT_ONE_Q16;
			2: return '1;
			default: return weight_t'($urandom_range(0, 17'h1FFFF));
		endcase
	endfunction

	function automatic plan_row_t row_cfg(reg_idx_t idx, weight_t val);
		return '{1'b1, idx, val, 8'h00, 1'b0, 1'b0, 8'h00};
	endfunction

	function automatic plan_row_t row_px(byte_t pix, bit eoi);
		return '{1'b0, REG_TAP_COUNT, 17'h0, pix, eoi, 1'b0, 8'h00};
	endfunction

	function automatic plan_row_t row_chk(byte_t pix, bit eoi, byte_t want_pix);
		return '{1'b0, REG_TAP_COUNT, 17'h0, pix, eoi, 1'b1, want_pix};
	endfunction

	// enter and leave at a falling edge; tvalid stays high for a back-to-back word
	task automatic send_pixel(byte_t pix, bit eoi, bit typed, filt_word_t want);
		int gap;
		gap = draw_gap(tx_mode);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = pix;
		s_axis_tlast  = eoi;
		predict_filter(pix, eoi);
		// a typed row gives exactly one word: replace the predicted one
		if (typed) filtered_q[filtered_q.size() - 1] = want;
		busy = 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// drain every expected word, then let the pipeline and any flush go quiet
	task automatic settle();
		s_axis_tvalid = 1'b0;
		while (filtered_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		busy = 1'b0;
	endtask

	task automatic write_reg(reg_idx_t idx, weight_t val);
		if (busy) settle();
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_TAP_COUNT) taps_reg = val[TAP_W-1:0];
		else tap_wgt[int'(idx) - int'(REG_WEIGHT_ZERO)] = val;
	endtask

	always @(posedge clk) begin
		filt_word_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (filtered_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("tb: unexpected word pixel=%02h last=%0b",
						m_axis_tdata, m_axis_tlast);
			end else begin
				want = filtered_q.pop_front();
				if (want.pix !== m_axis_tdata || want.last !== m_axis_tlast) begin
					mismatches++;
					if (mismatches <= 10)
						$display("tb: mismatch pixel exp=%02h got=%02h last exp=%0b got=%0b",
							want.pix, m_axis_tdata, want.last, m_axis_tlast);
				end
			end
		end
	end

	initial begin
		int gap;
		int rx_mode;
		int got;
		m_axis_tready = 1'b0;
		rx_mode = 0;
		got = 0;
		@(negedge clk);
		forever begin
			// hold off once for a long stretch so the filter backs up
			if (hold_req && !hold_done) begin
				m_axis_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end
			if (got % 32 == 0) rx_mode = int'($urandom_range(0, 2));
			gap = draw_gap(rx_mode);
			if (gap > 0) begin
				m_axis_tready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready = 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			got++;
			@(negedge clk);
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("tb: stalled for %0d cycles", STALL_LIMIT);
		$display("tb: failure");
		$finish;
	end

	initial begin
		plan_row_t plan[$];
		reg_idx_t  idx;
		int        sent;
		int        images;
		int        len;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		taps_reg      = taps_t'(1);
		for (int i = 0; i < MAX_TAPS; i++) tap_wgt[i] = '0;
		tap_wgt[0] = WEIGHT_ONE_Q16;
		win_fill = 0;

		// reset state: one tap of weight 1.0 passes bytes straight through
		plan = {plan, row_chk(8'h00, 1'b0, 8'h00)};
		plan = {plan, row_chk(8'hFF, 1'b0, 8'hFF)};
		plan = {plan, row_chk(8'h5A, 1'b1, 8'h5A)};
		// tap count of zero behaves as one tap
		plan = {plan, row_cfg(REG_TAP_COUNT, 17'd0)};
		plan = {plan, row_chk(8'h81, 1'b1, 8'h81)};
		plan = {plan, row_cfg(REG_WEIGHT_ZERO, 17'h00000)};
		plan = {plan, row_chk(8'hFF, 1'b1, 8'h00)};
		// seven taps at 1.0, image shorter than the tap count
		plan = {plan, row_cfg(REG_WEIGHT_ZERO, WEIGHT_ONE_Q16)};
		plan = {plan, row_cfg(REG_WEIGHT_ONE, WEIGHT_ONE_Q16)};
		plan = {plan, row_cfg(REG_WEIGHT_TWO, WEIGHT_ONE_Q16)};
		plan = {plan, row_cfg(REG_WEIGHT_THREE, WEIGHT_ONE_Q16)};
		plan = {plan, row_cfg(REG_WEIGHT_FOUR, WEIGHT_ONE_Q16)};
		plan = {plan, row_cfg(REG_WEIGHT_FIVE, WEIGHT_ONE_Q16)};
		plan = {plan, row_cfg(REG_WEIGHT_SIX, WEIGHT_ONE_Q16)};
		plan = {plan, row_cfg(REG_TAP_COUNT, 17'd7)};
		plan = {plan, row_px(8'hFF, 1'b0)};
		plan = {plan, row_px(8'hFF, 1'b0)};
		plan = {plan, row_px(8'h01, 1'b1)};
		// weights above 1.0 at their maximum, sum wraps
		plan = {plan, row_cfg(REG_WEIGHT_ZERO, 17'h1FFFF)};
		plan = {plan, row_cfg(REG_WEIGHT_ONE, 17'h1FFFF)};
		plan = {plan, row_cfg(REG_WEIGHT_TWO, 17'h1FFFF)};
		plan = {plan, row_cfg(REG_WEIGHT_THREE, 17'h1FFFF)};
		plan = {plan, row_cfg(REG_WEIGHT_FOUR, 17'h1FFFF)};
		plan = {plan, row_cfg(REG_WEIGHT_FIVE, 17'h1FFFF)};
		plan = {plan, row_cfg(REG_WEIGHT_SIX, 17'h1FFFF)};
		for (int i = 0; i < 7; i++) plan = {plan, row_px(8'hFF, 1'b0)};
		plan = {plan, row_px(8'hFE, 1'b1)};
		// tap count changed part-way through an image
		plan = {plan, row_cfg(REG_TAP_COUNT, 17'd3)};
		plan = {plan, row_cfg(REG_WEIGHT_ZERO, 17'h08000)};
		plan = {plan, row_cfg(REG_WEIGHT_ONE, 17'h04000)};
		plan = {plan, row_cfg(REG_WEIGHT_TWO, 17'h02000)};
		plan = {plan, row_px(8'h80, 1'b0)};
		plan = {plan, row_px(8'h40, 1'b0)};
		plan = {plan, row_cfg(REG_TAP_COUNT, 17'd5)};
		plan = {plan, row_px(8'h20, 1'b0)};
		plan = {plan, row_px(8'h10, 1'b0)};
		plan = {plan, row_px(8'h08, 1'b1)};
		// one-byte image with two taps
		plan = {plan, row_cfg(REG_TAP_COUNT, 17'd2)};
		plan = {plan, row_px(8'h7E, 1'b1)};

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[r]) begin
			if (plan[r].is_cfg)
				write_reg(plan[r].idx, plan[r].val);
			else
				send_pixel(plan[r].pix, plan[r].eoi, plan[r].typed,
					'{pix: plan[r].want_pix, last: plan[r].eoi});
		end

		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			write_reg(REG_TAP_COUNT, weight_t'($urandom_range(0, 7)));
			idx = REG_WEIGHT_ZERO;
			repeat (MAX_TAPS) begin
				if ($urandom_range(0, 1) == 1) write_reg(idx, pick_weight());
				idx = idx.next();
			end
			images = int'($urandom_range(1, 4));
			repeat (images) begin
				tx_mode = int'($urandom_range(0, 2));
				len = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 3)) :
					int'($urandom_range(4, 14));
				for (int k = 0; k < len; k++) begin
					if (k > 0 && $urandom_range(0, 15) == 0)
						write_reg(REG_TAP_COUNT, weight_t'($urandom_range(0, 7)));
					send_pixel(pick_pixel(), k == len - 1, 1'b0, '0);
					sent++;
				end
			end
		end

		// long image sent back to back while the receiver holds off
		tx_mode = 0;
		hold_req = 1'b1;
		for (int k = 0; k < BURST_PIXELS; k++)
			send_pixel(pick_pixel(), k == BURST_PIXELS - 1, 1'b0, '0);

		settle();
		if (filtered_q.size() != 0) begin
			mismatches++;
			$display("tb: %0d words never arrived", filtered_q.size());
		end
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
